[src/lkvc_pkg.sv]
// Package for the LRU key-value cache: sizes, command codes, controller states
// and the command struct passed from controller to datapath. No dependencies.
package lkvc_pkg;

    localparam int DEPTH     = 8;
    localparam int KEY_W     = 16;
    localparam int VAL_W     = 32;
    localparam int CAP_W     = 4;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W     = $clog2(DEPTH + 1);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture the incoming item
        logic exec;     // look up and update the entries
        logic cfg_we;   // write the capacity register
    } t_ctl_cmd;

endpackage

[src/lkvc_ctrl.sv]
// Controller of the LRU key-value cache: idle/execute state machine.
// Depends on lkvc_pkg.
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_cfg_valid,
    output logic     o_busy,
    output logic     o_cfg_ready,
    output t_ctl_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd.load   = (r_state == ST_IDLE) && i_start;
        o_cmd.exec   = (r_state == ST_EXEC);
        o_cmd.cfg_we = (r_state == ST_IDLE) && i_cfg_valid;
    end

endmodule

[src/lkvc_dp.sv]
// Datapath of the LRU key-value cache: entry registers, parallel key match,
// recency ranks, occupancy, capacity register and result registers.
// Depends on lkvc_pkg.
module lkvc_dp
    import lkvc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl_cmd                i_cmd,
    input  logic                    i_command,
    input  logic [KEY_W-1:0]        i_key,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic [CAP_W-1:0]        i_cfg_data,
    output logic                    o_valid,
    output logic                    o_hit,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic                    o_evicted,
    output logic [KEY_W-1:0]        o_evicted_key
);

    logic [KEY_W-1:0] r_keys   [DEPTH];
    logic [VAL_W-1:0] r_values [DEPTH];
    logic [IDX_W-1:0] r_rank   [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [OCC_W-1:0] r_occ;
    logic [CAP_W-1:0] r_cap;

    t_cmd             r_in_cmd;
    logic [KEY_W-1:0] r_in_key;
    logic [VAL_W-1:0] r_in_val;

    logic             r_out_valid;
    logic             r_out_hit;
    logic [VAL_W-1:0] r_out_rd;
    logic             r_out_ev;
    logic [KEY_W-1:0] r_out_evk;

    logic [DEPTH-1:0] match_vec;
    logic [DEPTH-1:0] lru_vec;
    logic             hit;
    logic             has_free;
    logic [IDX_W-1:0] match_idx;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] victim_idx;
    logic [IDX_W-1:0] tgt_idx;
    logic [IDX_W-1:0] tgt_rank;
    logic [OCC_W-1:0] occ_m1;
    logic [OCC_W-1:0] eff_cap;
    logic             can_fill;
    logic             do_fill;
    logic             do_evict;
    logic             do_touch;

    always_comb begin
        if (r_cap == '0) begin
            eff_cap = OCC_W'(1);
        end else if ({{(OCC_W > CAP_W ? OCC_W - CAP_W : 1){1'b0}}, r_cap}
                     > (OCC_W > CAP_W ? OCC_W : CAP_W + 1)'(DEPTH)) begin
            eff_cap = OCC_W'(DEPTH);
        end else begin
            eff_cap = OCC_W'(r_cap);
        end
    end

    assign occ_m1 = r_occ - OCC_W'(1);

    always_comb begin
        match_idx  = '0;
        free_idx   = '0;
        victim_idx = '0;
        has_free   = 1'b0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            match_vec[i] = r_valid[i] && (r_keys[i] == r_in_key);
            lru_vec[i]   = r_valid[i] && (OCC_W'(r_rank[i]) == occ_m1);
            if (match_vec[i]) begin
                match_idx = IDX_W'(i);
            end
            if (lru_vec[i]) begin
                victim_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
                has_free = 1'b1;
            end
        end
    end

    assign hit      = |match_vec;
    assign can_fill = (r_occ < eff_cap) && has_free;
    assign do_fill  = !hit && (r_in_cmd == CMD_PUT) && can_fill;
    assign do_evict = !hit && (r_in_cmd == CMD_PUT) && !can_fill;
    assign do_touch = hit || do_evict;
    assign tgt_idx  = hit ? match_idx : (do_fill ? free_idx : victim_idx);
    assign tgt_rank = r_rank[tgt_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_occ       <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_out_valid <= i_cmd.exec;
            if (i_cmd.cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (IDX_W'(i) == tgt_idx && (do_touch || do_fill)) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (do_fill ||
                                 (do_touch && r_rank[i] < tgt_rank))) begin
                        r_rank[i] <= r_rank[i] + IDX_W'(1);
                    end
                end
                if (do_fill) begin
                    r_valid[tgt_idx] <= 1'b1;
                    r_occ            <= r_occ + OCC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_cmd <= t_cmd'(i_command);
            r_in_key <= i_key;
            r_in_val <= i_value;
        end
        if (i_cmd.exec) begin
            if (r_in_cmd == CMD_PUT) begin
                r_values[tgt_idx] <= r_in_val;
                if (!hit) begin
                    r_keys[tgt_idx] <= r_in_key;
                end
            end
            r_out_hit <= hit;
            r_out_rd  <= (hit && r_in_cmd == CMD_GET) ? r_values[match_idx] : '0;
            r_out_ev  <= do_evict;
            r_out_evk <= do_evict ? r_keys[victim_idx] : '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_read_value  = r_out_rd;
    assign o_evicted     = r_out_ev;
    assign o_evicted_key = r_out_evk;

endmodule

[src/lru_key_value_cache_unit.sv]
// Top level of the LRU key-value cache: controller plus datapath.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_dp.
//
// Usage:
//   Command channel: drive i_command (0 get, 1 put), i_key, i_value and
//   raise start; the item is taken at an edge where start is high and busy
//   is low. busy is then high in the execute state while the eight
//   entries are matched in parallel and ranks, keys and values are updated.
//   Result channel: o_valid is high for exactly one cycle with o_hit,
//   o_read_value, o_evicted and o_evicted_key; it is registered at the end of
//   the execute state. The receiver cannot hold results off.
//   Items: a new one is taken only when idle, not in the single execute state of
//   the controller; the next item may start while the previous result shows.
//   Configuration: i_cfg_data (capacity in use) is written when i_cfg_valid
//   and o_cfg_ready are both high; o_cfg_ready is high whenever idle.
//   Reset (i_rst_n low, synchronous): all entries invalid, occupancy zero,
//   capacity eight, no result pending. Key and value storage is not cleared.
module lru_key_value_cache_unit
    import lkvc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_command,
    input  logic [KEY_W-1:0]        i_key,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_valid,
    output logic                    o_hit,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic                    o_evicted,
    output logic [KEY_W-1:0]        o_evicted_key,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CAP_W-1:0]        i_cfg_data
);

    t_ctl_cmd cmd;

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cfg_valid (i_cfg_valid),
        .o_busy      (busy),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    lkvc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

endmodule

[bench/testbench.sv]
// Self-checking bench for lru_key_value_cache_unit: directed and random get/put
// items checked against an in-bench LRU shadow model. Depends on lkvc_pkg.
module testbench;
    import lkvc_pkg::*;

    typedef struct {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic [KEY_W-1:0]        evicted_key;
    } t_reply;

    class lru_shadow;
        logic [KEY_W-1:0]        keys[DEPTH];
        logic signed [VAL_W-1:0] vals[DEPTH];
        bit                      valid[DEPTH];
        int unsigned             rank[DEPTH];
        int unsigned             occ;
        logic [CAP_W-1:0]        cap;
        t_reply                  pending[$];
        int                      errors;

        function void clear();
            foreach (valid[i]) begin
                valid[i] = 1'b0;
                rank[i]  = 0;
                keys[i]  = '0;
                vals[i]  = '0;
            end
            occ = 0;
            cap = CAP_RESET;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] c);
            cap = c;
        endfunction

        function int unsigned usable();
            int unsigned c;
            c = cap;
            if (c == 0) c = 1;
            if (c > DEPTH) c = DEPTH;
            return c;
        endfunction

        // slot s becomes most recent; newer valid entries age by one
        function void promote(int s);
            foreach (valid[i])
                if (valid[i] && i != s && rank[i] < rank[s]) rank[i]++;
            rank[s] = 0;
        endfunction

        function void take_command(t_cmd cmd, logic [KEY_W-1:0] key,
                                   logic signed [VAL_W-1:0] value);
            t_reply      r;
            int          match;
            int          slot;
            int unsigned oldest;
            r     = '{1'b0, '0, 1'b0, '0};
            match = -1;
            slot  = -1;
            foreach (valid[i])
                if (match < 0 && valid[i] && keys[i] == key) match = i;
            if (match >= 0) begin
                r.hit = 1'b1;
                if (cmd == CMD_GET) r.read_value = vals[match];
                else vals[match] = value;
                promote(match);
            end else if (cmd == CMD_PUT) begin
                if (occ < usable())
                    foreach (valid[i])
                        if (slot < 0 && !valid[i]) slot = i;
                if (slot >= 0) begin
                    foreach (valid[i])
                        if (valid[i]) rank[i]++;
                    valid[slot] = 1'b1;
                    rank[slot]  = 0;
                    occ++;
                end else begin
                    oldest = 0;
                    foreach (valid[i])
                        if (valid[i] && (slot < 0 || rank[i] > oldest)) begin
                            slot   = i;
                            oldest = rank[i];
                        end
                    r.evicted     = 1'b1;
                    r.evicted_key = keys[slot];
                    promote(slot);
                end
                keys[slot] = key;
                vals[slot] = value;
            end
            pending.push_back(r);
        endfunction

        function void check_reply(t_reply got);
            t_reply want;
            if (pending.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                errors++;
            end
            if (got.read_value !== want.read_value) begin
                $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
                errors++;
            end
            if (got.evicted !== want.evicted) begin
                $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                errors++;
            end
            if (got.evicted_key !== want.evicted_key) begin
                $error("evicted_key: expected %h, got %h", want.evicted_key, got.evicted_key);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    i_command = 1'b0;
    logic [KEY_W-1:0]        i_key = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    o_valid;
    logic                    o_hit;
    logic signed [VAL_W-1:0] o_read_value;
    logic                    o_evicted;
    logic [KEY_W-1:0]        o_evicted_key;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CAP_W-1:0]        i_cfg_data = '0;

    lru_shadow        shadow;
    bit               gapless;
    logic [KEY_W-1:0] key_pool[12];
    int               pool_size;

    lru_key_value_cache_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            shadow.check_reply('{o_hit, o_read_value, o_evicted, o_evicted_key});
    end

    function automatic bit take_gap();
        return !gapless && ($urandom_range(0, 99) < 38);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 7) == 0) return KEY_W'($urandom());
        return key_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    task automatic send_item(input t_cmd cmd, input logic [KEY_W-1:0] key,
                             input logic signed [VAL_W-1:0] value);
        while (take_gap()) begin
            start     <= 1'b0;
            i_command <= 1'($urandom());
            i_key     <= KEY_W'($urandom());
            i_value   <= $urandom();
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_key     <= key;
        i_value   <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        shadow.take_command(cmd, key, value);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge i_clk);
        while (shadow.pending.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_quiet();
        while (take_gap()) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow.set_capacity(cap);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int count);
        logic signed [VAL_W-1:0] value;
        write_capacity(cap);
        pool_size = $urandom_range(3, 12);
        foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom());
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int n = 0; n < count; n++) begin
            value = $urandom();
            if ($urandom_range(0, 9) == 0)
                case ($urandom_range(0, 3))
                    0: value = '0;
                    1: value = -1;
                    2: value = {1'b1, {(VAL_W-1){1'b0}}};
                    default: value = {1'b0, {(VAL_W-1){1'b1}}};
                endcase
            if ($urandom_range(0, 49) == 0) wait_quiet();
            send_item(($urandom_range(0, 99) < 55) ? CMD_PUT : CMD_GET, pick_key(), value);
        end
    endtask

    initial begin
        logic [CAP_W-1:0] caps[12];
        caps = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd7, 4'd3, 4'd12, 4'd4, 4'd6, 4'd9, 4'd5};
        shadow = new;
        shadow.clear();
        gapless = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty miss, extremes, put hit, get miss
        send_item(CMD_GET, 16'h0000, 32'sd5);
        send_item(CMD_PUT, 16'h0000, 32'sh7fff_ffff);
        send_item(CMD_PUT, 16'hffff, 32'sh8000_0000);
        send_item(CMD_GET, 16'hffff, 32'sd0);
        send_item(CMD_GET, 16'h0000, -32'sd1);
        send_item(CMD_PUT, 16'h0000, -32'sd1);
        send_item(CMD_GET, 16'h0000, 32'sd0);
        send_item(CMD_GET, 16'h0001, 32'sd0);
        send_item(CMD_PUT, 16'h0001, 32'sd0);
        // capacity dropped below occupancy, then zero, then above depth
        write_capacity(4'd1);
        send_item(CMD_PUT, 16'h0002, 32'sd2);
        send_item(CMD_GET, 16'h0000, 32'sd0);
        send_item(CMD_PUT, 16'h0003, 32'sd3);
        write_capacity(4'd0);
        send_item(CMD_PUT, 16'h0004, 32'sd4);
        send_item(CMD_PUT, 16'h0004, 32'sd44);
        send_item(CMD_GET, 16'h0004, 32'sd0);
        write_capacity(4'd15);
        for (int k = 0; k < 8; k++)
            send_item(CMD_PUT, 16'h0100 + KEY_W'(k), 32'sd100 + k);
        send_item(CMD_GET, 16'h0104, 32'sd0);

        foreach (caps[p]) begin
            gapless = (p == 4);
            run_phase(caps[p], 42);
        end
        gapless = 1'b0;

        wait_quiet();
        if (shadow.errors == 0 && shadow.pending.size() == 0)
            $display("lru_key_value_cache_unit regression: pass");
        else
            $display("lru_key_value_cache_unit regression: fail");
        $finish;
    end

    initial begin
        #3000000;
        $display("lru_key_value_cache_unit regression: fail");
        $finish;
    end

endmodule
